// ===== hdl/clmp_pkg.sv =====
// ----------------------------------------------------------------------------
// clmp_pkg
// Shared types and constants for the CPU list to mask parser.
// ----------------------------------------------------------------------------
`default_nettype none

package clmp_pkg;

    localparam int CPU_COUNT_DEFAULT = 64;
    localparam int MASK_W            = 64;
    localparam int NUM_W             = 16;
    localparam int CHAR_W            = 8;
    localparam int STATUS_W          = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Status codes reported with each result.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REVERSED  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_COMMA,
        TK_DASH,
        TK_OTHER,
        TK_END
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [3:0]  digit;
    } token_t;

endpackage

`default_nettype wire

// ===== hdl/clmp_front.sv =====
// ----------------------------------------------------------------------------
// clmp_front
// Classifies each incoming character beat into a token for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clmp_front (
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [clmp_pkg::CHAR_W-1:0]  s_tdata,
    input  wire logic                         s_tuser,
    input  wire logic                         q_full,
    output logic                              q_push,
    output clmp_pkg::token_t                  q_token
);

    logic [clmp_pkg::CHAR_W-1:0] digit_off;

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;
    assign digit_off = s_tdata - clmp_pkg::CH_ZERO;

    always_comb begin
        q_token.digit = digit_off[3:0];
        if (s_tuser) begin
            q_token.kind = clmp_pkg::TK_END;
        end else if (s_tdata >= clmp_pkg::CH_ZERO && s_tdata <= clmp_pkg::CH_NINE) begin
            q_token.kind = clmp_pkg::TK_DIGIT;
        end else if (s_tdata == clmp_pkg::CH_COMMA) begin
            q_token.kind = clmp_pkg::TK_COMMA;
        end else if (s_tdata == clmp_pkg::CH_DASH) begin
            q_token.kind = clmp_pkg::TK_DASH;
        end else begin
            q_token.kind = clmp_pkg::TK_OTHER;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/clmp_queue.sv =====
// ----------------------------------------------------------------------------
// clmp_queue
// Short token queue that decouples the classifier from the segment engine.
// ----------------------------------------------------------------------------
`default_nettype none

module clmp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire clmp_pkg::token_t  push_token,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output clmp_pkg::token_t       head_token
);

    clmp_pkg::token_t mem [clmp_pkg::QUEUE_DEPTH];

    logic [clmp_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [clmp_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [clmp_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       do_pop;

    assign full       = count_reg == clmp_pkg::CNT_W'(clmp_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_token = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == clmp_pkg::PTR_W'(clmp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == clmp_pkg::PTR_W'(clmp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= clmp_pkg::CNT_W'(clmp_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ===== hdl/clmp_back.sv =====
// ----------------------------------------------------------------------------
// clmp_back
// Segment engine: accumulates numbers, closes segments into the mask and
// holds the finished result until the output side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module clmp_back #(
    parameter int CPU_COUNT = clmp_pkg::CPU_COUNT_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           tok_valid,
    input  wire clmp_pkg::token_t               tok,
    output logic                                tok_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [clmp_pkg::MASK_W-1:0]         m_tdata,
    output logic [clmp_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int NUM_W  = clmp_pkg::NUM_W;
    localparam int MASK_W = clmp_pkg::MASK_W;
    localparam int PROD_W = NUM_W + 4;
    localparam logic [NUM_W-1:0] CPU_LIMIT = NUM_W'(CPU_COUNT);

    logic [MASK_W-1:0]            mask_reg, mask_next;
    logic [NUM_W-1:0]             num_reg, num_next;
    logic [NUM_W-1:0]             start_reg, start_next;
    logic                         digit_reg, digit_next;
    logic                         dash_reg, dash_next;
    logic                         any_reg, any_next;
    logic [clmp_pkg::STATUS_W-1:0] err_reg, err_next;

    logic                          out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]             out_mask_reg, out_mask_next;
    logic [clmp_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic [NUM_W-1:0]              seg_lo;
    logic [MASK_W-1:0]             seg_mask;
    logic [clmp_pkg::STATUS_W-1:0] close_err;
    logic [PROD_W-1:0]             acc_sum;
    logic [NUM_W-1:0]              acc_sat;
    logic                          is_end;
    logic [clmp_pkg::STATUS_W-1:0] fin_err;
    logic [MASK_W-1:0]             fin_mask;

    assign is_end   = tok.kind == clmp_pkg::TK_END;
    assign tok_pop  = tok_valid && (!is_end || !out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mask_reg;
    assign m_tuser  = out_status_reg;

    // A single number is a range from itself to itself.
    assign seg_lo = dash_reg ? start_reg : num_reg;

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            seg_mask[i] = (NUM_W'(i) >= seg_lo) && (NUM_W'(i) <= num_reg);
        end
    end

    always_comb begin
        if (!digit_reg) begin
            close_err = clmp_pkg::ST_MALFORMED;
        end else if (dash_reg && num_reg < start_reg) begin
            close_err = clmp_pkg::ST_REVERSED;
        end else if (num_reg >= CPU_LIMIT) begin
            close_err = clmp_pkg::ST_RANGE;
        end else begin
            close_err = clmp_pkg::ST_OK;
        end
    end

    assign acc_sum = ({4'b0, num_reg} << 3) + ({4'b0, num_reg} << 1) + PROD_W'(tok.digit);
    assign acc_sat = (acc_sum > PROD_W'({NUM_W{1'b1}})) ? {NUM_W{1'b1}} : acc_sum[NUM_W-1:0];

    // The end marker closes the open segment only when something came before it.
    always_comb begin
        fin_err  = err_reg;
        fin_mask = mask_reg;
        if (any_reg && err_reg == clmp_pkg::ST_OK) begin
            fin_err = close_err;
            if (close_err == clmp_pkg::ST_OK) begin
                fin_mask = mask_reg | seg_mask;
            end
        end
    end

    always_comb begin
        mask_next       = mask_reg;
        num_next        = num_reg;
        start_next      = start_reg;
        digit_next      = digit_reg;
        dash_next       = dash_reg;
        any_next        = any_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_mask_next   = out_mask_reg;
        out_status_next = out_status_reg;

        if (tok_pop) begin
            if (is_end) begin
                out_valid_next  = 1'b1;
                out_mask_next   = (fin_err == clmp_pkg::ST_OK) ? fin_mask : '0;
                out_status_next = fin_err;
                mask_next  = '0;
                num_next   = '0;
                start_next = '0;
                digit_next = 1'b0;
                dash_next  = 1'b0;
                any_next   = 1'b0;
                err_next   = clmp_pkg::ST_OK;
            end else begin
                any_next = 1'b1;
                if (err_reg == clmp_pkg::ST_OK) begin
                    unique case (tok.kind)
                        clmp_pkg::TK_DIGIT: begin
                            num_next   = acc_sat;
                            digit_next = 1'b1;
                        end
                        clmp_pkg::TK_COMMA: begin
                            err_next = close_err;
                            if (close_err == clmp_pkg::ST_OK) begin
                                mask_next = mask_reg | seg_mask;
                            end
                            num_next   = '0;
                            start_next = '0;
                            digit_next = 1'b0;
                            dash_next  = 1'b0;
                        end
                        clmp_pkg::TK_DASH: begin
                            if (dash_reg || !digit_reg) begin
                                err_next = clmp_pkg::ST_MALFORMED;
                            end else begin
                                start_next = num_reg;
                                dash_next  = 1'b1;
                                num_next   = '0;
                                digit_next = 1'b0;
                            end
                        end
                        default: begin
                            err_next = clmp_pkg::ST_MALFORMED;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            num_reg       <= '0;
            start_reg     <= '0;
            digit_reg     <= 1'b0;
            dash_reg      <= 1'b0;
            any_reg       <= 1'b0;
            err_reg       <= clmp_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            mask_reg      <= mask_next;
            num_reg       <= num_next;
            start_reg     <= start_next;
            digit_reg     <= digit_next;
            dash_reg      <= dash_next;
            any_reg       <= any_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_mask_reg   <= out_mask_next;
        out_status_reg <= out_status_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != clmp_pkg::ST_OK) |-> out_mask_reg == '0)
        else $error("mask reported together with an error");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_pop && is_end) |=> out_valid_reg && err_reg == clmp_pkg::ST_OK
                                && mask_reg == '0 && !any_reg)
        else $error("end marker did not publish a result and clear the state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_mask_reg)
                                         && $stable(out_status_reg))
        else $error("held result changed before it was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != clmp_pkg::ST_OK && !(tok_pop && is_end)) |=> err_reg == $past(err_reg))
        else $error("first error was overwritten");

endmodule

`default_nettype wire

// ===== hdl/cpu_list_to_mask_parser_top.sv =====
// ----------------------------------------------------------------------------
// cpu_list_to_mask_parser_top
// Parses a CPU list string such as 0-3,5 into a CPU bit mask and a status.
// ----------------------------------------------------------------------------
// Characters enter one per beat on the s_ side; a beat with s_tuser high is
// the end marker and carries no character. Each beat, the end marker too,
// takes one queue entry, so a string streams in without gaps; the limit is
// the segment engine, which folds one token per cycle into the number and
// mask registers unless an end marker must wait for the held result to be
// taken. An end marker passes the token queue and then the output register.
// A four-entry token queue sits between the character classifier and the
// segment engine, and the result sits in its own output register, so new
// characters keep flowing while a result waits to be taken.
// Status: 0 ok, 1 malformed, 2 CPU out of range, 3 reversed range; the mask
// is zero whenever the status is not ok.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_list_to_mask_parser_top #(
    parameter int CPU_COUNT = clmp_pkg::CPU_COUNT_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [clmp_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] ch
    input  wire logic                             s_tuser,   // [0] end_of_string
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [clmp_pkg::MASK_W-1:0]           m_tdata,   // [63:0] cpu_mask
    output logic [clmp_pkg::STATUS_W-1:0]         m_tuser    // [1:0] status
);

    logic             q_full;
    logic             q_push;
    clmp_pkg::token_t q_token;
    logic             q_pop;
    logic             head_valid;
    clmp_pkg::token_t head_token;

    clmp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_token  (q_token)
    );

    clmp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (q_token),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    clmp_back #(
        .CPU_COUNT (CPU_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (head_valid),
        .tok       (head_token),
        .tok_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CPU list to mask parser.
// ----------------------------------------------------------------------------
// Character strings are streamed into the parser one beat at a time. Each
// string is closed by an end-marker beat. A parser model inside the bench
// follows every accepted beat and queues the mask and status that each
// end marker should produce. Each result beat is compared with the oldest
// queued entry. The stimulus begins with hand-picked strings that cover the
// error cases and the mask edges. It goes on with random lists, most of them
// well formed, some corrupted and some pure byte noise. Both sides stall at
// random, except during a closing stretch with no stalls at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_W       = clmp_pkg::CHAR_W;
    localparam int MASK_W       = clmp_pkg::MASK_W;
    localparam int NUM_W        = clmp_pkg::NUM_W;
    localparam int STATUS_W     = clmp_pkg::STATUS_W;
    localparam int CPUS         = clmp_pkg::CPU_COUNT_DEFAULT;
    localparam int NUM_SAT      = 65535;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1300;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [MASK_W-1:0]   m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    typedef struct {
        logic [MASK_W-1:0]   mask;
        logic [STATUS_W-1:0] status;
    } cpu_result_t;

    cpu_result_t pending_masks[$];

    // Parser model state.
    logic [MASK_W-1:0]   lm_mask;
    logic [NUM_W-1:0]    lm_number;
    logic                lm_digit;
    logic [NUM_W-1:0]    lm_start;
    logic                lm_dash;
    logic                lm_any;
    logic [STATUS_W-1:0] lm_error;

    int unsigned mismatch_count  = 0;
    int unsigned beats_sent      = 0;
    int unsigned strings_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};
    int unsigned cycle_count     = 0;
    bit          quiet_tail      = 1'b0;
    int unsigned ready_hold      = 0;

    cpu_list_to_mask_parser_top #(
        .CPU_COUNT(CPUS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [7:0] ch
        .s_tuser (s_tuser),   // [0] end_of_string
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [63:0] cpu_mask
        .m_tuser (m_tuser)    // [1:0] status
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_masks.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic logic [MASK_W-1:0] low_bits(int unsigned n);
        if (n >= MASK_W - 1)
            return '1;
        return (64'd1 << (n + 1)) - 64'd1;
    endfunction

    task automatic model_clear_segment();
        lm_number = '0;
        lm_digit  = 1'b0;
        lm_start  = '0;
        lm_dash   = 1'b0;
    endtask

    task automatic model_reset();
        lm_mask  = '0;
        model_clear_segment();
        lm_any   = 1'b0;
        lm_error = clmp_pkg::ST_OK;
    endtask

    task automatic model_close_segment();
        logic [MASK_W-1:0] below;
        if (!lm_digit) begin
            lm_error = clmp_pkg::ST_MALFORMED;
        end else if (lm_dash) begin
            // The reversed check wins over the range check on the end.
            if (lm_number < lm_start) begin
                lm_error = clmp_pkg::ST_REVERSED;
            end else if (lm_number >= CPUS) begin
                lm_error = clmp_pkg::ST_RANGE;
            end else begin
                below   = (lm_start == 0) ? '0 : low_bits(lm_start - 1);
                lm_mask = lm_mask | (low_bits(lm_number) & ~below);
            end
        end else if (lm_number >= CPUS) begin
            lm_error = clmp_pkg::ST_RANGE;
        end else begin
            lm_mask = lm_mask | (64'd1 << lm_number);
        end
        model_clear_segment();
    endtask

    task automatic model_beat(input logic [CHAR_W-1:0] ch, input logic eos);
        cpu_result_t r;
        int unsigned v;
        if (eos) begin
            if (lm_any && lm_error == clmp_pkg::ST_OK)
                model_close_segment();
            r.mask   = (lm_error == clmp_pkg::ST_OK) ? lm_mask : '0;
            r.status = lm_error;
            pending_masks.push_back(r);
            model_reset();
            return;
        end
        lm_any = 1'b1;
        if (lm_error != clmp_pkg::ST_OK)
            return;
        if (ch >= clmp_pkg::CH_ZERO && ch <= clmp_pkg::CH_NINE) begin
            v = int'(lm_number) * 10 + int'(ch - clmp_pkg::CH_ZERO);
            lm_number = (v > NUM_SAT) ? NUM_W'(NUM_SAT) : NUM_W'(v);
            lm_digit  = 1'b1;
        end else if (ch == clmp_pkg::CH_COMMA) begin
            model_close_segment();
        end else if (ch == clmp_pkg::CH_DASH) begin
            if (lm_dash || !lm_digit) begin
                lm_error = clmp_pkg::ST_MALFORMED;
            end else begin
                lm_start  = lm_number;
                lm_dash   = 1'b1;
                lm_number = '0;
                lm_digit  = 1'b0;
            end
        end else begin
            lm_error = clmp_pkg::ST_MALFORMED;
        end
    endtask

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [CHAR_W-1:0] ch, input logic eos);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= eos;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        model_beat(ch, eos);
    endtask

    // The end marker carries a random byte that the parser must ignore.
    task automatic send_string(input string text);
        for (int i = 0; i < text.len(); i++)
            send_beat(text[i], 1'b0);
        send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
        strings_sent++;
    endtask

    // The last beat is withdrawn so that it is not taken a second time.
    task automatic wait_drained();
        if (pending_masks.size() != 0) begin
            s_tvalid <= 1'b0;
            while (pending_masks.size() != 0) @(posedge aclk);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [MASK_W-1:0] want,
                                   input logic [MASK_W-1:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (quiet_tail) begin
            m_tready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            ready_hold <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        cpu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_masks.size() == 0) begin
                report_mismatch("result beat with nothing pending", '0, m_tdata);
            end else begin
                want = pending_masks.pop_front();
                results_checked++;
                status_seen[m_tuser]++;
                if (m_tdata !== want.mask)
                    report_mismatch("cpu_mask", want.mask, m_tdata);
                if (m_tuser !== want.status)
                    report_mismatch("status", MASK_W'(want.status), MASK_W'(m_tuser));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random string builders
    // ------------------------------------------------------------------
    function automatic string number_text();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $sformatf("%0d", $urandom_range(0, CPUS - 1));
        if (r < 90)
            return $sformatf("%0d", $urandom_range(CPUS, 300));
        if (r < 95)
            return $sformatf("%0d", $urandom_range(65000, 999999));
        return $sformatf("00%0d", $urandom_range(0, CPUS - 1));
    endfunction

    function automatic string well_formed_list();
        string       text;
        int unsigned segs;
        int unsigned lo;
        int unsigned hi;
        text = "";
        segs = $urandom_range(1, 5);
        for (int i = 0; i < segs; i++) begin
            if (i > 0)
                text = {text, ","};
            case ($urandom_range(0, 9))
                0, 1, 2, 3: text = {text, number_text()};
                4: text = {text, number_text(), "-", number_text()};
                default: begin
                    lo = $urandom_range(0, CPUS - 1);
                    hi = $urandom_range(lo, CPUS - 1);
                    text = {text, $sformatf("%0d-%0d", lo, hi)};
                end
            endcase
        end
        return text;
    endfunction

    function automatic string broken_list();
        string       text;
        int unsigned pos;
        byte         bad;
        text = well_formed_list();
        pos  = $urandom_range(0, text.len() - 1);
        case ($urandom_range(0, 5))
            0: bad = " ";
            1: bad = ",";
            2: bad = "-";
            3: bad = "+";
            4: bad = "x";
            default: bad = byte'($urandom_range(1, 255));
        endcase
        text[pos] = bad;
        return text;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_lists();
        send_string("");
        send_string("0-3,5");
        send_string("0");
        send_string("63");
        send_string("0-63");
        send_string("62-63,7-7");
        send_string("0,1,2,61,62,63");
    endtask

    task automatic test_malformed_lists();
        send_string("1,,2");
        send_string("1,");
        send_string(",");
        send_string("3-");
        send_string("-3");
        send_string("1-2-3");
        send_string(" 1");
        send_string("+1");
        // The first error must stick even when a later segment is also bad.
        send_string("1x,5-2,99");
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        strings_sent++;
    endtask

    task automatic test_range_errors();
        send_string("64");
        send_string("5-2");
        send_string("70-5");
        send_string("5-70");
        send_string("99999");
        send_string("0-3,4-2,99");
    endtask

    task automatic test_random_lists();
        int unsigned pick;
        int unsigned len;
        while (beats_sent < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_string(well_formed_list());
            end else if (pick < 85) begin
                send_string(broken_list());
            end else begin
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++)
                    send_beat(CHAR_W'($urandom_range(0, 255)), 1'b0);
                send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
                strings_sent++;
            end
        end
    endtask

    // Each string waits for the result of the one before it.
    task automatic test_drained_strings();
        for (int i = 0; i < 6; i++) begin
            wait_drained();
            send_string(well_formed_list());
        end
        wait_drained();
    endtask

    task automatic test_back_to_back();
        quiet_tail = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_string(well_formed_list());
            send_string("");
        end
    endtask

    initial begin
        model_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_lists();
        test_malformed_lists();
        test_range_errors();
        test_random_lists();
        test_drained_strings();
        test_back_to_back();

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Sent %0d beats in %0d strings; checked %0d results.",
                 beats_sent, strings_sent, results_checked);
        $display("Status counts: ok %0d, malformed %0d, out of range %0d, reversed %0d.",
                 status_seen[clmp_pkg::ST_OK], status_seen[clmp_pkg::ST_MALFORMED],
                 status_seen[clmp_pkg::ST_RANGE], status_seen[clmp_pkg::ST_REVERSED]);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
